/* hdl/dps_pkg.sv */
// Shared types and codes of the dynamic priority scheduler.
package dps_pkg;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    localparam logic [1:0] ST_ADMITTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RAN      = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

    typedef struct packed {
        logic               operation;
        logic        [7:0]  process_id;
        logic signed [15:0] priority_req;
        logic        [15:0] run_time;
    } t_sched_in;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [7:0]  ran_process_id;
        logic signed [15:0] new_priority;
        logic        [15:0] remaining_time;
        logic               finished;
        logic        [3:0]  waiting_count;
    } t_sched_out;

    typedef struct packed {
        logic        [7:0]  pid;
        logic signed [15:0] prio;
        logic        [15:0] slices;
    } t_slot;

endpackage

/* hdl/dynamic_priority_scheduler.sv */
// Top level: highest priority first scheduler with aging, insertion sequencer.
//
//  channel   ports                     handshake
//  command   start, i_cmd, busy        taken when start && !busy
//  result    o_done, o_result          valid for the one cycle o_done is high
//
// A table-full admit or an empty-table run answers in the cycle after start.
// An admit steps past entries from the tail, moving each one place toward the tail,
// until it meets a strictly higher entry or reaches the head, then writes itself.
// A run reads and ages the head entry and answers if it finishes; otherwise the aged
// entry is put back into the table the way an admit would be.
// The table memory (one write port, one registered read port) and its one
// comparator make the sequencer step through the entries one at a time.
// Synchronous reset empties the table; slot contents are left as they are.
// The receiver cannot stall: each result appears once, for one cycle.
module dynamic_priority_scheduler #(
    parameter int DEPTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  dps_pkg::t_sched_in   i_cmd,
    output logic                 busy,
    output logic                 o_done,
    output dps_pkg::t_sched_out  o_result
);
    import dps_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_INS_RD  = 2'd1;
    localparam logic [1:0] S_INS_CMP = 2'd2;
    localparam logic [1:0] S_RUN_EX  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_occ,   n_occ;
    logic [IW-1:0] r_head,  n_head;
    logic [IW-1:0] r_pos,   n_pos;
    t_slot         r_new,   n_new;
    logic          r_done,  n_done;
    t_sched_out    r_res,   n_res;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_slot         ram_wdata;
    logic [IW-1:0] ram_raddr;
    t_slot         ram_q;

    logic signed [15:0] aged_prio;
    logic        [15:0] aged_slices;

    // Map a place in the sorted order to a slot, counting from the head.
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [IW-1:0] rank);
        logic [IW:0] sum;
        sum = {1'b0, head} + {1'b0, rank};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    function automatic logic [3:0] count4(input logic [CW-1:0] cnt);
        logic [CW+3:0] ext;
        ext = {4'b0000, cnt};
        return ext[3:0];
    endfunction

    dps_slot_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign aged_prio   = (ram_q.prio == PRIO_MIN) ? ram_q.prio : ram_q.prio - 16'sd1;
    assign aged_slices = (ram_q.slices == 16'd0) ? 16'd0 : ram_q.slices - 16'd1;

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_head    = r_head;
        n_pos     = r_pos;
        n_new     = r_new;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = phys(r_head, r_pos);
        ram_wdata = r_new;
        ram_raddr = (r_state == S_IDLE) ? r_head : phys(r_head, r_pos - IW'(1));

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res = '0;
                    if (i_cmd.operation == OP_ADMIT) begin
                        if (r_occ == DEPTH_C) begin
                            n_res.status        = ST_FULL;
                            n_res.waiting_count = count4(r_occ);
                            n_done              = 1'b1;
                        end else begin
                            n_res.status = ST_ADMITTED;
                            n_new.pid    = i_cmd.process_id;
                            n_new.prio   = i_cmd.priority_req;
                            n_new.slices = i_cmd.run_time;
                            n_pos        = r_occ[IW-1:0];
                            n_state      = S_INS_RD;
                        end
                    end else if (r_occ == '0) begin
                        n_res.status        = ST_EMPTY;
                        n_res.waiting_count = count4(r_occ);
                        n_done              = 1'b1;
                    end else begin
                        // head read issued this cycle
                        n_state = S_RUN_EX;
                    end
                end
            end
            S_RUN_EX: begin
                n_res.status         = ST_RAN;
                n_res.ran_process_id = ram_q.pid;
                n_res.new_priority   = aged_prio;
                n_res.remaining_time = aged_slices;
                n_res.finished       = (aged_slices == 16'd0);
                n_head = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
                n_occ  = r_occ - CW'(1);
                if (aged_slices == 16'd0) begin
                    n_res.waiting_count = count4(n_occ);
                    n_done              = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_new.pid    = ram_q.pid;
                    n_new.prio   = aged_prio;
                    n_new.slices = aged_slices;
                    n_pos        = n_occ[IW-1:0];
                    n_state      = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    ram_we              = 1'b1;
                    n_occ               = r_occ + CW'(1);
                    n_res.waiting_count = count4(n_occ);
                    n_done              = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (ram_q.prio > r_new.prio) begin
                    // stop behind the first strictly higher entry
                    n_occ               = r_occ + CW'(1);
                    n_res.waiting_count = count4(n_occ);
                    n_done              = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    // move that entry one place toward the tail
                    ram_wdata = ram_q;
                    n_pos     = r_pos - IW'(1);
                    n_state   = S_INS_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_head  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_head  <= n_head;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_new <= n_new;
        r_res <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

/* hdl/dps_slot_ram.sv */
// Ready table storage: one write port, one registered read port.
module dps_slot_ram #(
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  dps_pkg::t_slot             i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output dps_pkg::t_slot             o_rdata
);
    import dps_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/tb_dynamic_priority_scheduler.sv */
// Testbench for the dynamic priority scheduler: directed and random commands, scoreboard check.
module tb_dynamic_priority_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import dps_pkg::*;

    localparam int SLOTS = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    t_sched_in  i_cmd;
    logic       busy;
    logic       o_done;
    t_sched_out o_result;

    class sched_scoreboard;
        t_slot      ready_q[$];
        t_sched_out expected_q[$];
        int         error_count = 0;

        task report_mismatch(string field, logic signed [31:0] got_v,
                             logic signed [31:0] want_v);
            error_count++;
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got_v, want_v);
        endtask

        // Go ahead of the first entry whose priority is not greater.
        function void insert_slot(t_slot s);
            int pos;
            pos = 0;
            while (pos < ready_q.size() && ready_q[pos].prio > s.prio) pos++;
            ready_q.insert(pos, s);
        endfunction

        function void note_command(t_sched_in cmd);
            t_sched_out r;
            t_slot      s;
            r = '0;
            if (cmd.operation == OP_ADMIT) begin
                if (ready_q.size() >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    s.pid    = cmd.process_id;
                    s.prio   = cmd.priority_req;
                    s.slices = cmd.run_time;
                    insert_slot(s);
                    r.status = ST_ADMITTED;
                end
            end else if (ready_q.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                s = ready_q.pop_front();
                // Age the head; the priority saturates at the floor.
                if (s.prio != PRIO_MIN) s.prio = s.prio - 16'sd1;
                if (s.slices != 16'd0) s.slices = s.slices - 16'd1;
                r.status         = ST_RAN;
                r.ran_process_id = s.pid;
                r.new_priority   = s.prio;
                r.remaining_time = s.slices;
                r.finished       = (s.slices == 16'd0);
                if (s.slices != 16'd0) insert_slot(s);
            end
            r.waiting_count = 4'(ready_q.size());
            expected_q.push_back(r);
        endfunction

        task check_result(t_sched_out got);
            t_sched_out want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, status", got.status, -1);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.ran_process_id !== want.ran_process_id)
                report_mismatch("ran_process_id", got.ran_process_id, want.ran_process_id);
            if (got.new_priority !== want.new_priority)
                report_mismatch("new_priority", got.new_priority, want.new_priority);
            if (got.remaining_time !== want.remaining_time)
                report_mismatch("remaining_time", got.remaining_time, want.remaining_time);
            if (got.finished !== want.finished)
                report_mismatch("finished", got.finished, want.finished);
            if (got.waiting_count !== want.waiting_count)
                report_mismatch("waiting_count", got.waiting_count, want.waiting_count);
        endtask
    endclass

    sched_scoreboard sb;

    dynamic_priority_scheduler #(
        .DEPTH(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #1 i_clk = ~i_clk;

    // Result of an earlier transaction is checked before the one accepted at this edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_done) sb.check_result(o_result);
            if (start && !busy) sb.note_command(i_cmd);
        end
    end

    function automatic t_sched_in make_cmd(logic op, logic [7:0] pid,
                                           logic signed [15:0] prio, logic [15:0] rt);
        t_sched_in c;
        c.operation    = op;
        c.process_id   = pid;
        c.priority_req = prio;
        c.run_time     = rt;
        return c;
    endfunction

    function automatic t_sched_in random_cmd(int run_pct);
        t_sched_in c;
        c.operation  = ($urandom_range(99) < run_pct) ? OP_RUN : OP_ADMIT;
        c.process_id = 8'($urandom);
        case ($urandom_range(9))
            0:       c.priority_req = PRIO_MIN;
            1:       c.priority_req = 16'sh7FFF;
            2, 3, 4: c.priority_req = 16'($urandom);
            // Crowd around zero to get plenty of ties.
            default: c.priority_req = 16'(int'($urandom_range(4)) - 2);
        endcase
        // Long jobs camp in the table, so keep them rare.
        if ($urandom_range(149) == 0)
            c.run_time = 16'($urandom);
        else
            c.run_time = 16'($urandom_range(6, 1));
        return c;
    endfunction

    // Hold the command until an edge with busy low takes it.
    task automatic issue_cmd(t_sched_in cmd);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        issue_cmd(make_cmd(OP_RUN, 8'h00, 16'sd0, 16'd0));
        issue_cmd(make_cmd(OP_ADMIT, 8'h00, 16'sh7FFF, 16'd1));
        issue_cmd(make_cmd(OP_ADMIT, 8'hFF, PRIO_MIN, 16'd0));
        issue_cmd(make_cmd(OP_ADMIT, 8'hA5, 16'sd0, 16'd1));
        issue_cmd(make_cmd(OP_ADMIT, 8'h5A, 16'sd0, 16'd2));
        issue_cmd(make_cmd(OP_ADMIT, 8'h11, PRIO_MIN, 16'd3));
        issue_cmd(make_cmd(OP_ADMIT, 8'h3C, -16'sd1, 16'd2));
        issue_cmd(make_cmd(OP_ADMIT, 8'hC3, 16'sd100, 16'd1));
        issue_cmd(make_cmd(OP_ADMIT, 8'h7E, 16'sd0, 16'd1));
        // Table is full now: this one is rejected.
        issue_cmd(make_cmd(OP_ADMIT, 8'h81, -16'sd2, 16'hFFFF));
        repeat (14) issue_cmd(make_cmd(OP_RUN, 8'hFF, 16'sh7FFF, 16'hFFFF));
    endtask

    initial begin
        int run_pct;
        sb = new();
        run_pct = 50;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < 135; n++) begin
                // Swing between filling and draining the table.
                if (n % 16 == 0) run_pct = 25 * $urandom_range(3, 1);
                issue_cmd(random_cmd(run_pct));
                idle_gap(phase == 0 ? 27 : (phase == 1 ? 49 : 0));
            end
        end
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch("results never seen", sb.expected_q.size(), 0);
        if (sb.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #200_000;
        $display("FAILURE");
        $finish;
    end

endmodule
